// ----- rtl/smbb_pkg.sv -----
// Shared types, register codes and reset values for the skin motion bounding box block.
// Used by every module under rtl; depends on nothing.
package smbb_pkg;

    localparam int MAX_FRAME_DIM_DEF = 4096;
    localparam int APB_ADDR_W        = 5;
    localparam int APB_DATA_W        = 32;
    localparam int PIX_W             = 8;
    localparam int BOX_W             = 12;
    localparam int DIM_W             = 13;
    localparam int MID_DEPTH         = 2;
    localparam int OUT_DEPTH         = 4;

    typedef enum logic [2:0] {
        REG_DIFF_THRESHOLD = 3'd0,
        REG_CR_LOWER       = 3'd1,
        REG_CR_UPPER       = 3'd2,
        REG_CB_LOWER       = 3'd3,
        REG_CB_UPPER       = 3'd4,
        REG_MIN_BOX_SIZE   = 3'd5,
        REG_FRAME_WIDTH    = 3'd6,
        REG_FRAME_HEIGHT   = 3'd7
    } t_reg_idx;

    localparam logic [PIX_W-1:0] DIFF_THRESHOLD_RST = 8'd20;
    localparam logic [PIX_W-1:0] CR_LOWER_RST       = 8'd77;
    localparam logic [PIX_W-1:0] CR_UPPER_RST       = 8'd127;
    localparam logic [PIX_W-1:0] CB_LOWER_RST       = 8'd133;
    localparam logic [PIX_W-1:0] CB_UPPER_RST       = 8'd173;
    localparam logic [BOX_W-1:0] MIN_BOX_SIZE_RST   = 12'd10;
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST    = 13'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST   = 13'd480;

    typedef enum logic {
        KIND_MASK = 1'b0,
        KIND_BOX  = 1'b1
    } t_kind;

    typedef enum logic {
        BK_PIXEL = 1'b0,
        BK_BOX   = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [PIX_W-1:0] diff_threshold;
        logic [PIX_W-1:0] cr_lower;
        logic [PIX_W-1:0] cr_upper;
        logic [PIX_W-1:0] cb_lower;
        logic [PIX_W-1:0] cb_upper;
        logic [BOX_W-1:0] min_box_size;
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
    } t_cfg;

    typedef struct packed {
        logic             result_kind;
        logic             is_skin;
        logic [BOX_W-1:0] box_x;
        logic [BOX_W-1:0] box_y;
        logic [BOX_W-1:0] box_width;
        logic [BOX_W-1:0] box_height;
        logic             last;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- rtl/skin_motion_bounding_box_core.sv -----
// Top level of the skin motion bounding box block: register file, front, queues, back.
// Depends on smbb_pkg, smbb_regs, smbb_front, smbb_queue and smbb_back.
//
// Pixels enter in raster order through push/full, one per clock while full is low. Every pixel
// gives one mask transaction; the last pixel of a frame gives a second, the bounding box. A taken
// pixel is written to the two-entry queue between front and back; the back end then moves its
// mask transaction into the four-entry output queue that drives the result ports. At the end of
// each frame the back end pauses to issue the box transaction: the two-entry queue takes
// the pixel offered meanwhile, and full then rises while that queue drains. The output queue
// absorbs short stalls on the result side. Frame size and thresholds are to be written through
// the APB port while no pixel is in flight; the block itself does not enforce this.
module skin_motion_bounding_box_core
    import smbb_pkg::*;
#(
    parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  push,
    output logic                  full,
    input  logic [PIX_W-1:0]      i_gray_now,
    input  logic [PIX_W-1:0]      i_gray_background,
    input  logic [PIX_W-1:0]      i_chroma_red,
    input  logic [PIX_W-1:0]      i_chroma_blue,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_result_kind,
    output logic                  o_is_skin,
    output logic [BOX_W-1:0]      o_box_x,
    output logic [BOX_W-1:0]      o_box_y,
    output logic [BOX_W-1:0]      o_box_width,
    output logic [BOX_W-1:0]      o_box_height,
    output logic                  o_last
);

    localparam int CW     = $clog2(MAX_FRAME_DIM);
    localparam int ITEM_W = 2 * CW + 2;
    localparam int RES_W  = $bits(t_result);

    t_cfg              w_cfg;
    t_q_status         w_mid_stat;
    t_q_status         w_out_stat;
    logic              w_mid_push;
    logic              w_mid_pop;
    logic [ITEM_W-1:0] w_mid_wdata;
    logic [ITEM_W-1:0] w_mid_rdata;
    logic              w_out_push;
    t_result           w_out_wdata;
    logic [RES_W-1:0]  w_out_rdata;
    t_result           w_res;

    smbb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    smbb_front #(
        .MAX_FRAME_DIM (MAX_FRAME_DIM)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (w_cfg),
        .i_push            (push),
        .o_full            (full),
        .i_gray_now        (i_gray_now),
        .i_gray_background (i_gray_background),
        .i_chroma_red      (i_chroma_red),
        .i_chroma_blue     (i_chroma_blue),
        .i_q_stat          (w_mid_stat),
        .o_q_push          (w_mid_push),
        .o_q_data          (w_mid_wdata)
    );

    smbb_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_wdata),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_rdata),
        .o_stat  (w_mid_stat)
    );

    smbb_back #(
        .MAX_FRAME_DIM (MAX_FRAME_DIM)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_min_box_size (w_cfg.min_box_size),
        .i_q_stat       (w_mid_stat),
        .i_q_data       (w_mid_rdata),
        .o_q_pop        (w_mid_pop),
        .i_out_stat     (w_out_stat),
        .o_out_push     (w_out_push),
        .o_out_data     (w_out_wdata)
    );

    smbb_queue #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_wdata),
        .i_pop   (pop),
        .o_data  (w_out_rdata),
        .o_stat  (w_out_stat)
    );

    assign w_res         = t_result'(w_out_rdata);
    assign empty         = w_out_stat.empty;
    assign o_result_kind = w_res.result_kind;
    assign o_is_skin     = w_res.is_skin;
    assign o_box_x       = w_res.box_x;
    assign o_box_y       = w_res.box_y;
    assign o_box_width   = w_res.box_width;
    assign o_box_height  = w_res.box_height;
    assign o_last        = w_res.last;

endmodule

// ----- rtl/smbb_regs.sv -----
// Configuration register file behind the APB-style port.
// Depends on smbb_pkg for the register codes, reset values and t_cfg.
module smbb_regs
    import smbb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.diff_threshold <= DIFF_THRESHOLD_RST;
            r_cfg.cr_lower       <= CR_LOWER_RST;
            r_cfg.cr_upper       <= CR_UPPER_RST;
            r_cfg.cb_lower       <= CB_LOWER_RST;
            r_cfg.cb_upper       <= CB_UPPER_RST;
            r_cfg.min_box_size   <= MIN_BOX_SIZE_RST;
            r_cfg.frame_width    <= FRAME_WIDTH_RST;
            r_cfg.frame_height   <= FRAME_HEIGHT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DIFF_THRESHOLD: r_cfg.diff_threshold <= pwdata[PIX_W-1:0];
                REG_CR_LOWER:       r_cfg.cr_lower       <= pwdata[PIX_W-1:0];
                REG_CR_UPPER:       r_cfg.cr_upper       <= pwdata[PIX_W-1:0];
                REG_CB_LOWER:       r_cfg.cb_lower       <= pwdata[PIX_W-1:0];
                REG_CB_UPPER:       r_cfg.cb_upper       <= pwdata[PIX_W-1:0];
                REG_MIN_BOX_SIZE:   r_cfg.min_box_size   <= pwdata[BOX_W-1:0];
                REG_FRAME_WIDTH:    r_cfg.frame_width    <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT:   r_cfg.frame_height   <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DIFF_THRESHOLD: prdata = APB_DATA_W'(r_cfg.diff_threshold);
            REG_CR_LOWER:       prdata = APB_DATA_W'(r_cfg.cr_lower);
            REG_CR_UPPER:       prdata = APB_DATA_W'(r_cfg.cr_upper);
            REG_CB_LOWER:       prdata = APB_DATA_W'(r_cfg.cb_lower);
            REG_CB_UPPER:       prdata = APB_DATA_W'(r_cfg.cb_upper);
            REG_MIN_BOX_SIZE:   prdata = APB_DATA_W'(r_cfg.min_box_size);
            REG_FRAME_WIDTH:    prdata = APB_DATA_W'(r_cfg.frame_width);
            REG_FRAME_HEIGHT:   prdata = APB_DATA_W'(r_cfg.frame_height);
            default:            prdata = '0;
        endcase
    end

endmodule

// ----- rtl/smbb_queue.sv -----
// Small register-based first-in first-out queue, used between front and back and on the output.
// Depends on smbb_pkg for the t_q_status struct.
module smbb_queue
    import smbb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_status        o_stat
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CNTW-1:0]  r_count;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    n_rd;
    logic [CNTW-1:0]  n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_stat.full  = (r_count == CNTW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count + CNTW'(w_do_push) - CNTW'(w_do_pop);
        if (w_do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (w_do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/smbb_front.sv -----
// Front end: accepts pixels, classifies skin, runs the column and row counters.
// Depends on smbb_pkg for t_cfg and t_q_status.
module smbb_front
    import smbb_pkg::*;
#(
    parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_cfg                               i_cfg,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic [PIX_W-1:0]                   i_gray_now,
    input  logic [PIX_W-1:0]                   i_gray_background,
    input  logic [PIX_W-1:0]                   i_chroma_red,
    input  logic [PIX_W-1:0]                   i_chroma_blue,
    input  t_q_status                          i_q_stat,
    output logic                               o_q_push,
    output logic [2*$clog2(MAX_FRAME_DIM)+1:0] o_q_data
);

    localparam int CW = $clog2(MAX_FRAME_DIM);
    localparam int DW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;

    function automatic logic [DW-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DW-1:0] ext;
        ext = DW'(v);
        if (v == '0) return DW'(1);
        if (ext > DW'(MAX_FRAME_DIM)) return DW'(MAX_FRAME_DIM);
        return ext;
    endfunction

    logic [CW-1:0]    r_col;
    logic [CW-1:0]    r_row;
    logic [CW-1:0]    n_col;
    logic [CW-1:0]    n_row;
    logic [DW-1:0]    w_width;
    logic [DW-1:0]    w_height;
    logic [PIX_W-1:0] w_diff;
    logic             w_skin;
    logic             w_row_end;
    logic             w_frame_end;
    logic             w_accept;

    assign w_width     = eff_dim(i_cfg.frame_width);
    assign w_height    = eff_dim(i_cfg.frame_height);
    assign w_diff      = (i_gray_now >= i_gray_background) ? i_gray_now - i_gray_background
                                                           : i_gray_background - i_gray_now;
    assign w_skin      = (w_diff > i_cfg.diff_threshold)
                      && (i_chroma_red > i_cfg.cr_lower) && (i_chroma_red < i_cfg.cr_upper)
                      && (i_chroma_blue > i_cfg.cb_lower) && (i_chroma_blue < i_cfg.cb_upper);
    assign w_row_end   = DW'(r_col) >= (w_width - DW'(1));
    assign w_frame_end = w_row_end && (DW'(r_row) >= (w_height - DW'(1)));

    assign o_full   = i_q_stat.full;
    assign w_accept = i_push && !i_q_stat.full;
    assign o_q_push = w_accept;
    assign o_q_data = {w_skin, w_frame_end, r_col, r_row};

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            n_col = w_row_end ? '0 : r_col + CW'(1);
            if (w_frame_end) begin
                n_row = '0;
            end else if (w_row_end) begin
                n_row = r_row + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ----- rtl/smbb_back.sv -----
// Back end: widens the bounding box and issues mask and end-of-frame box transactions.
// Depends on smbb_pkg for t_result, t_q_status and the back-end state type.
module smbb_back
    import smbb_pkg::*;
#(
    parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [BOX_W-1:0]                   i_min_box_size,
    input  t_q_status                          i_q_stat,
    input  logic [2*$clog2(MAX_FRAME_DIM)+1:0] i_q_data,
    output logic                               o_q_pop,
    input  t_q_status                          i_out_stat,
    output logic                               o_out_push,
    output t_result                            o_out_data
);

    localparam int CW     = $clog2(MAX_FRAME_DIM);
    localparam int ITEM_W = 2 * CW + 2;
    localparam int MW     = (CW > BOX_W) ? CW : BOX_W;

    t_back_state   r_state;
    t_back_state   n_state;
    logic [CW-1:0] r_left;
    logic [CW-1:0] r_top;
    logic [CW-1:0] r_right;
    logic [CW-1:0] r_bottom;
    logic          r_seen;
    logic [CW-1:0] n_left;
    logic [CW-1:0] n_top;
    logic [CW-1:0] n_right;
    logic [CW-1:0] n_bottom;
    logic          n_seen;

    logic          w_skin;
    logic          w_end;
    logic [CW-1:0] w_x;
    logic [CW-1:0] w_y;
    logic [MW-1:0] w_bw;
    logic [MW-1:0] w_bh;
    logic [MW-1:0] w_min;
    logic [MW-1:0] w_left;
    logic [MW-1:0] w_top;
    logic          w_small;

    assign w_skin  = i_q_data[ITEM_W-1];
    assign w_end   = i_q_data[ITEM_W-2];
    assign w_x     = i_q_data[2*CW-1:CW];
    assign w_y     = i_q_data[CW-1:0];

    assign w_bw    = MW'(r_right - r_left);
    assign w_bh    = MW'(r_bottom - r_top);
    assign w_min   = MW'(i_min_box_size);
    assign w_left  = MW'(r_left);
    assign w_top   = MW'(r_top);
    assign w_small = (w_bw <= w_min) || (w_bh <= w_min);

    always_comb begin
        n_state    = r_state;
        n_left     = r_left;
        n_top      = r_top;
        n_right    = r_right;
        n_bottom   = r_bottom;
        n_seen     = r_seen;
        o_q_pop    = 1'b0;
        o_out_push = 1'b0;
        o_out_data = '0;
        unique case (r_state)
            BK_PIXEL: begin
                if (!i_q_stat.empty && !i_out_stat.full) begin
                    o_q_pop                = 1'b1;
                    o_out_push             = 1'b1;
                    o_out_data.result_kind = KIND_MASK;
                    o_out_data.is_skin     = w_skin;
                    o_out_data.last        = !w_end;
                    if (w_skin) begin
                        if (!r_seen) begin
                            n_left   = w_x;
                            n_top    = w_y;
                            n_right  = w_x;
                            n_bottom = w_y;
                            n_seen   = 1'b1;
                        end else begin
                            if (w_x < r_left)   n_left   = w_x;
                            if (w_y < r_top)    n_top    = w_y;
                            if (w_x > r_right)  n_right  = w_x;
                            if (w_y > r_bottom) n_bottom = w_y;
                        end
                    end
                    if (w_end) begin
                        n_state = BK_BOX;
                    end
                end
            end
            BK_BOX: begin
                if (!i_out_stat.full) begin
                    o_out_push             = 1'b1;
                    o_out_data.result_kind = KIND_BOX;
                    o_out_data.box_x       = w_left[BOX_W-1:0];
                    o_out_data.box_y       = w_top[BOX_W-1:0];
                    o_out_data.box_width   = w_small ? i_min_box_size : w_bw[BOX_W-1:0];
                    o_out_data.box_height  = w_small ? i_min_box_size : w_bh[BOX_W-1:0];
                    o_out_data.last        = 1'b1;
                    n_seen                 = 1'b0;
                    n_state                = BK_PIXEL;
                end
            end
            default: n_state = BK_PIXEL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_PIXEL;
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= '0;
            r_bottom <= '0;
            r_seen   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_left   <= n_left;
            r_top    <= n_top;
            r_right  <= n_right;
            r_bottom <= n_bottom;
            r_seen   <= n_seen;
        end
    end

endmodule

// ----- rtl/smbb_checker.sv -----
// Port-level checks on skin_motion_bounding_box_core, attached by the bind at the end.
// Depends on smbb_pkg for field widths and the result kind codes.
module smbb_checker
    import smbb_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input logic             o_result_kind,
    input logic             o_is_skin,
    input logic [BOX_W-1:0] o_box_x,
    input logic [BOX_W-1:0] o_box_y,
    input logic [BOX_W-1:0] o_box_width,
    input logic [BOX_W-1:0] o_box_height,
    input logic             o_last
);

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_box_shape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_result_kind == KIND_BOX) |-> o_last && !o_is_skin)
        else $error("box transaction with last clear or skin set");

    a_mask_shape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_result_kind == KIND_MASK)
            |-> (o_box_x == '0) && (o_box_y == '0)
                && (o_box_width == '0) && (o_box_height == '0))
        else $error("mask transaction carries box fields");

    a_box_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && (o_result_kind == KIND_MASK) && !o_last
            |=> !empty && (o_result_kind == KIND_BOX))
        else $error("end-of-frame mask not followed by box transaction");

endmodule

bind skin_motion_bounding_box_core smbb_checker u_checker (.*);
